// ===== src/kdt_pkg.sv =====
// Shared types, constants and codes for the kd-tree ray traversal block.
`timescale 1ns / 1ps
package kdt_pkg;

    localparam int NODE_COUNT  = 4096;
    localparam int STACK_DEPTH = 64;
    localparam int FRAC_BITS   = 16;

    localparam int NODE_AW     = $clog2(NODE_COUNT);
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int VISIT_LIMIT = 2 * NODE_COUNT + 2 * STACK_DEPTH;
    localparam int STEP_W      = $clog2(VISIT_LIMIT + 1);
    localparam int DIV_STEPS   = 2 * FRAC_BITS;
    localparam int DIV_CW      = $clog2(DIV_STEPS + 1);
    localparam int QUOT_W      = DIV_STEPS + 1;

    localparam logic [1:0] CMD_NODE   = 2'd0;
    localparam logic [1:0] CMD_ORIGIN = 2'd1;
    localparam logic [1:0] CMD_TRACE  = 2'd2;

    localparam logic [1:0] AXIS_LEAF  = 2'd3;

    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_ROOT_NODE = 3'd1;
    localparam logic [2:0] REG_BOX_MIN_X = 3'd2;
    localparam logic [2:0] REG_BOX_MIN_Y = 3'd3;
    localparam logic [2:0] REG_BOX_MIN_Z = 3'd4;
    localparam logic [2:0] REG_BOX_MAX_X = 3'd5;
    localparam logic [2:0] REG_BOX_MAX_Y = 3'd6;
    localparam logic [2:0] REG_BOX_MAX_Z = 3'd7;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [11:0]        node_index;
        logic [11:0]        left_child;
        logic [11:0]        right_child;
        logic [1:0]         split_axis;
        logic signed [31:0] split_pos;
        logic [15:0]        value_min;
        logic [15:0]        value_max;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
    } in_item_t;

    typedef struct packed {
        logic [15:0] hit_value;
        logic        stack_overflow;
    } out_item_t;

    typedef struct packed {
        logic [11:0]        right;
        logic [11:0]        left;
        logic [1:0]         axis;
        logic signed [31:0] split;
        logic [15:0]        vmax;
        logic [15:0]        vmin;
    } node_word_t;

    typedef struct packed {
        logic signed [31:0] hi;
        logic signed [31:0] lo;
        logic [11:0]        node;
    } stack_word_t;

    typedef struct packed {
        logic       in_take;
        logic [1:0] axis;
        logic       div_init;
        logic       div_step;
        logic       div_lead;
        logic       div_store;
        logic       mul_split;
        logic       mul_hi;
        logic       mul_load;
        logic       mul_prod;
        logic       mul_shift;
        logic       clip_apply;
        logic       clamp_init;
        logic       fetch;
        logic       decide;
        logic       pop_read;
        logic       pop_load;
        logic       out_load;
        logic       out_hit;
    } dp_cmd_t;

    typedef struct packed {
        logic div_zero;
        logic skip;
        logic leaf;
        logic stack_empty;
        logic step_over;
    } dp_status_t;

endpackage

// ===== src/kdt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module kdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/kdt_datapath.sv =====
// Datapath: config, ray state, reciprocal divider, multiplier, node table and stack.
`timescale 1ns / 1ps
module kdt_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  kdt_pkg::in_item_t  in_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  kdt_pkg::dp_cmd_t   cmd,
    output kdt_pkg::dp_status_t status,
    output kdt_pkg::out_item_t out_data
);

    localparam int NODE_W  = $bits(kdt_pkg::node_word_t);
    localparam int STACK_W = $bits(kdt_pkg::stack_word_t);

    logic [15:0]                 thr_reg;
    logic [11:0]                 root_reg;
    logic signed [31:0]          box_lo_reg [3];
    logic signed [31:0]          box_hi_reg [3];
    logic signed [31:0]          origin_reg [3];
    logic signed [31:0]          dir_reg [3];
    logic signed [31:0]          inv_reg [3];

    logic [32:0]                 rem_reg;
    logic [kdt_pkg::QUOT_W-1:0]  quot_reg;
    logic [31:0]                 mag_reg;

    logic signed [31:0]          mul_a_reg;
    logic signed [31:0]          mul_b_reg;
    logic signed [63:0]          prod_reg;
    logic signed [31:0]          res_reg;

    logic signed [31:0]          rmin_reg;
    logic signed [31:0]          rmax_reg;
    logic [kdt_pkg::NODE_AW-1:0] node_reg;
    logic [kdt_pkg::CNT_W-1:0]   count_reg;
    logic                        ovf_reg;
    logic [kdt_pkg::STEP_W-1:0]  steps_reg;
    kdt_pkg::out_item_t          out_reg;

    logic [NODE_W-1:0]           node_rdata;
    logic [STACK_W-1:0]          stack_rdata;
    kdt_pkg::node_word_t         node_q;
    kdt_pkg::node_word_t         node_w;
    kdt_pkg::stack_word_t        stack_q;
    kdt_pkg::stack_word_t        stack_w;

    logic [1:0]                  axis_sel;
    logic signed [31:0]          sel_dir;
    logic signed [31:0]          sel_org;
    logic signed [31:0]          sel_inv;
    logic signed [31:0]          sel_blo;
    logic signed [31:0]          sel_bhi;
    logic signed [31:0]          plane;
    logic signed [32:0]          diff;
    logic signed [31:0]          diff_sat;
    logic signed [63:0]          shifted;
    logic signed [31:0]          shift_sat;
    logic [31:0]                 mag;
    logic [32:0]                 trial;
    logic                        trial_ge;
    logic [31:0]                 quot_sat;
    logic signed [31:0]          inv_val;
    logic                        t_near;
    logic                        t_far;
    logic                        push;
    logic [11:0]                 near_c;
    logic [11:0]                 far_c;

    assign node_q  = kdt_pkg::node_word_t'(node_rdata);
    assign stack_q = kdt_pkg::stack_word_t'(stack_rdata);

    assign axis_sel = cmd.mul_split ? node_q.axis : cmd.axis;

    always_comb
    begin
        case (axis_sel)
            2'd0:
            begin
                sel_dir = dir_reg[0];
                sel_org = origin_reg[0];
                sel_inv = inv_reg[0];
                sel_blo = box_lo_reg[0];
                sel_bhi = box_hi_reg[0];
            end
            2'd1:
            begin
                sel_dir = dir_reg[1];
                sel_org = origin_reg[1];
                sel_inv = inv_reg[1];
                sel_blo = box_lo_reg[1];
                sel_bhi = box_hi_reg[1];
            end
            default:
            begin
                sel_dir = dir_reg[2];
                sel_org = origin_reg[2];
                sel_inv = inv_reg[2];
                sel_blo = box_lo_reg[2];
                sel_bhi = box_hi_reg[2];
            end
        endcase
    end

    // negative direction swaps the entry and exit planes
    always_comb
    begin
        if (cmd.mul_split)
        begin
            plane = node_q.split;
        end
        else if (cmd.mul_hi ^ sel_dir[31])
        begin
            plane = sel_bhi;
        end
        else
        begin
            plane = sel_blo;
        end
    end

    assign diff = {plane[31], plane} - {sel_org[31], sel_org};
    always_comb
    begin
        if (diff[32] != diff[31])
        begin
            diff_sat = diff[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        else
        begin
            diff_sat = diff[31:0];
        end
    end

    // arithmetic shift is floor rounding
    assign shifted = prod_reg >>> kdt_pkg::FRAC_BITS;
    always_comb
    begin
        if (shifted[63:31] != {33{shifted[63]}})
        begin
            shift_sat = shifted[63] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        else
        begin
            shift_sat = shifted[31:0];
        end
    end

    assign mag      = sel_dir[31] ? 32'(-sel_dir) : 32'(sel_dir);
    assign trial    = {rem_reg[31:0], cmd.div_lead};
    assign trial_ge = trial >= {1'b0, mag_reg};
    assign quot_sat = (quot_reg > kdt_pkg::QUOT_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF
                                                                 : quot_reg[31:0];
    always_comb
    begin
        if (status.div_zero)
        begin
            inv_val = 32'sh7FFFFFFF;
        end
        else if (sel_dir[31])
        begin
            inv_val = -$signed(quot_sat);
        end
        else
        begin
            inv_val = $signed(quot_sat);
        end
    end

    assign near_c = sel_dir[31] ? node_q.right : node_q.left;
    assign far_c  = sel_dir[31] ? node_q.left : node_q.right;
    assign t_near = rmax_reg <= res_reg;
    assign t_far  = rmin_reg >= res_reg;
    assign push   = cmd.decide && !t_near && !t_far
                    && (count_reg < kdt_pkg::CNT_W'(kdt_pkg::STACK_DEPTH));

    assign status.div_zero    = (sel_dir == 32'sd0);
    assign status.skip        = (node_q.vmax < thr_reg) || (rmin_reg >= rmax_reg);
    assign status.leaf        = (node_q.axis == kdt_pkg::AXIS_LEAF)
                                || (node_q.vmin == node_q.vmax);
    assign status.stack_empty = (count_reg == '0);
    assign status.step_over   = (steps_reg == kdt_pkg::STEP_W'(kdt_pkg::VISIT_LIMIT));

    always_comb
    begin
        node_w.left  = in_data.left_child;
        node_w.right = in_data.right_child;
        node_w.axis  = in_data.split_axis;
        node_w.split = in_data.split_pos;
        node_w.vmin  = in_data.value_min;
        node_w.vmax  = in_data.value_max;
        stack_w.hi   = rmax_reg;
        stack_w.lo   = res_reg;
        stack_w.node = far_c;
    end

    kdt_ram #(
        .WIDTH(NODE_W),
        .DEPTH(kdt_pkg::NODE_COUNT)
    ) u_node_ram (
        .clk  (clk),
        .we   (cmd.in_take && (in_data.cmd == kdt_pkg::CMD_NODE)),
        .waddr(in_data.node_index[kdt_pkg::NODE_AW-1:0]),
        .wdata(node_w),
        .re   (cmd.fetch),
        .raddr(node_reg),
        .rdata(node_rdata)
    );

    kdt_ram #(
        .WIDTH(STACK_W),
        .DEPTH(kdt_pkg::STACK_DEPTH)
    ) u_stack_ram (
        .clk  (clk),
        .we   (push),
        .waddr(count_reg[kdt_pkg::STACK_AW-1:0]),
        .wdata(stack_w),
        .re   (cmd.pop_read),
        .raddr(kdt_pkg::STACK_AW'(count_reg - 1'b1)),
        .rdata(stack_rdata)
    );

    // configuration and ray origin
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= '0;
            root_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                box_lo_reg[i] <= '0;
                box_hi_reg[i] <= '0;
                origin_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    kdt_pkg::REG_THRESHOLD: thr_reg       <= cfg_data[15:0];
                    kdt_pkg::REG_ROOT_NODE: root_reg      <= cfg_data[11:0];
                    kdt_pkg::REG_BOX_MIN_X: box_lo_reg[0] <= cfg_data;
                    kdt_pkg::REG_BOX_MIN_Y: box_lo_reg[1] <= cfg_data;
                    kdt_pkg::REG_BOX_MIN_Z: box_lo_reg[2] <= cfg_data;
                    kdt_pkg::REG_BOX_MAX_X: box_hi_reg[0] <= cfg_data;
                    kdt_pkg::REG_BOX_MAX_Y: box_hi_reg[1] <= cfg_data;
                    default:                box_hi_reg[2] <= cfg_data;
                endcase
            end
            if (cmd.in_take && (in_data.cmd == kdt_pkg::CMD_ORIGIN))
            begin
                origin_reg[0] <= in_data.vec_x;
                origin_reg[1] <= in_data.vec_y;
                origin_reg[2] <= in_data.vec_z;
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.in_take && (in_data.cmd == kdt_pkg::CMD_TRACE))
        begin
            dir_reg[0] <= in_data.vec_x;
            dir_reg[1] <= in_data.vec_y;
            dir_reg[2] <= in_data.vec_z;
        end
        if (cmd.div_init)
        begin
            rem_reg  <= '0;
            quot_reg <= '0;
            mag_reg  <= mag;
        end
        if (cmd.div_step)
        begin
            rem_reg  <= trial_ge ? (trial - {1'b0, mag_reg}) : trial;
            quot_reg <= {quot_reg[kdt_pkg::QUOT_W-2:0], trial_ge};
        end
        if (cmd.div_store)
        begin
            case (cmd.axis)
                2'd0:    inv_reg[0] <= inv_val;
                2'd1:    inv_reg[1] <= inv_val;
                default: inv_reg[2] <= inv_val;
            endcase
        end
        if (cmd.mul_load)
        begin
            mul_a_reg <= diff_sat;
            mul_b_reg <= sel_inv;
        end
        if (cmd.mul_prod)
        begin
            prod_reg <= mul_a_reg * mul_b_reg;
        end
        if (cmd.mul_shift)
        begin
            res_reg <= shift_sat;
        end
        if (cmd.clip_apply)
        begin
            if (cmd.mul_hi)
            begin
                if ((cmd.axis == 2'd0) || (res_reg < rmax_reg))
                begin
                    rmax_reg <= res_reg;
                end
            end
            else if ((cmd.axis == 2'd0) || (res_reg > rmin_reg))
            begin
                rmin_reg <= res_reg;
            end
        end
        if (cmd.clamp_init)
        begin
            if (rmin_reg < 0)
            begin
                rmin_reg <= '0;
            end
            if (rmax_reg < 0)
            begin
                rmax_reg <= '0;
            end
            node_reg  <= root_reg[kdt_pkg::NODE_AW-1:0];
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            steps_reg <= '0;
        end
        if (cmd.fetch)
        begin
            steps_reg <= steps_reg + 1'b1;
        end
        if (cmd.decide)
        begin
            if (t_near)
            begin
                node_reg <= near_c[kdt_pkg::NODE_AW-1:0];
            end
            else if (t_far)
            begin
                node_reg <= far_c[kdt_pkg::NODE_AW-1:0];
            end
            else
            begin
                if (push)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
                rmax_reg <= res_reg;
                node_reg <= near_c[kdt_pkg::NODE_AW-1:0];
            end
        end
        if (cmd.pop_read)
        begin
            count_reg <= count_reg - 1'b1;
        end
        if (cmd.pop_load)
        begin
            rmin_reg <= stack_q.lo;
            rmax_reg <= stack_q.hi;
            node_reg <= stack_q.node[kdt_pkg::NODE_AW-1:0];
        end
        if (cmd.out_load)
        begin
            out_reg.hit_value      <= cmd.out_hit ? node_q.vmax : 16'd0;
            out_reg.stack_overflow <= ovf_reg;
        end
    end

    assign out_data = out_reg;

endmodule

// ===== src/kdt_ctrl.sv =====
// Controller: sequences reciprocals, box clipping and the tree walk.
`timescale 1ns / 1ps
module kdt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          in_cmd,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output kdt_pkg::dp_cmd_t    cmd,
    input  kdt_pkg::dp_status_t status
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DIV_INIT  = 4'd1;
    localparam logic [3:0] S_DIV_RUN   = 4'd2;
    localparam logic [3:0] S_DIV_STORE = 4'd3;
    localparam logic [3:0] S_MUL_LOAD  = 4'd4;
    localparam logic [3:0] S_MUL_PROD  = 4'd5;
    localparam logic [3:0] S_MUL_SHIFT = 4'd6;
    localparam logic [3:0] S_CLIP      = 4'd7;
    localparam logic [3:0] S_CLAMP     = 4'd8;
    localparam logic [3:0] S_FETCH     = 4'd9;
    localparam logic [3:0] S_NODE      = 4'd10;
    localparam logic [3:0] S_DECIDE    = 4'd11;
    localparam logic [3:0] S_POP       = 4'd12;
    localparam logic [3:0] S_POP_LOAD  = 4'd13;
    localparam logic [3:0] S_DONE      = 4'd14;

    logic [3:0]                  state_reg, state_next;
    logic [kdt_pkg::DIV_CW-1:0]  cnt_reg, cnt_next;
    logic [2:0]                  j_reg, j_next;
    logic                        mode_reg, mode_next;
    logic                        hit_reg, hit_next;
    logic                        out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        j_next         = j_reg;
        mode_next      = mode_reg;
        hit_next       = hit_reg;
        cmd            = '0;
        cmd.mul_split  = mode_reg;
        cmd.mul_hi     = j_reg[0];
        cmd.axis       = (state_reg inside {S_DIV_INIT, S_DIV_RUN, S_DIV_STORE})
                         ? j_reg[1:0] : j_reg[2:1];
        in_stall       = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.in_take = 1'b1;
                    if (in_cmd == kdt_pkg::CMD_TRACE)
                    begin
                        j_next     = '0;
                        mode_next  = 1'b0;
                        state_next = S_DIV_INIT;
                    end
                end
            end
            S_DIV_INIT:
            begin
                if (status.div_zero)
                begin
                    state_next = S_DIV_STORE;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    cnt_next     = kdt_pkg::DIV_CW'(kdt_pkg::DIV_STEPS);
                    state_next   = S_DIV_RUN;
                end
            end
            S_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                cmd.div_lead = (cnt_reg == kdt_pkg::DIV_CW'(kdt_pkg::DIV_STEPS));
                if (cnt_reg == '0)
                begin
                    state_next = S_DIV_STORE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_DIV_STORE:
            begin
                cmd.div_store = 1'b1;
                if (j_reg == 3'd2)
                begin
                    j_next     = '0;
                    state_next = S_MUL_LOAD;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_DIV_INIT;
                end
            end
            S_MUL_LOAD:
            begin
                cmd.mul_load = 1'b1;
                state_next   = S_MUL_PROD;
            end
            S_MUL_PROD:
            begin
                cmd.mul_prod = 1'b1;
                state_next   = S_MUL_SHIFT;
            end
            S_MUL_SHIFT:
            begin
                cmd.mul_shift = 1'b1;
                state_next    = mode_reg ? S_DECIDE : S_CLIP;
            end
            S_CLIP:
            begin
                cmd.clip_apply = 1'b1;
                if (j_reg == 3'd5)
                begin
                    state_next = S_CLAMP;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_MUL_LOAD;
                end
            end
            S_CLAMP:
            begin
                cmd.clamp_init = 1'b1;
                mode_next      = 1'b1;
                state_next     = S_FETCH;
            end
            S_FETCH:
            begin
                if (status.step_over)
                begin
                    hit_next   = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.fetch  = 1'b1;
                    state_next = S_NODE;
                end
            end
            S_NODE:
            begin
                if (status.skip)
                begin
                    if (status.stack_empty)
                    begin
                        hit_next   = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_POP;
                    end
                end
                else if (status.leaf)
                begin
                    hit_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_MUL_LOAD;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_FETCH;
            end
            S_POP:
            begin
                cmd.pop_read = 1'b1;
                state_next   = S_POP_LOAD;
            end
            S_POP_LOAD:
            begin
                cmd.pop_load = 1'b1;
                state_next   = S_FETCH;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_hit  = hit_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            j_reg         <= '0;
            mode_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            j_reg         <= j_next;
            mode_reg      <= mode_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && out_stall))
        else $error("result overwritten while stalled");

    // a trace transfer starts the reciprocal sequence
    a_trace_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (in_cmd == kdt_pkg::CMD_TRACE)) |=>
        (state_reg == S_DIV_INIT))
        else $error("trace did not start");

    // pops only from a non-empty stack
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_read |-> !status.stack_empty)
        else $error("pop from empty stack");

endmodule

// ===== src/kd_tree_volume_ray_traversal.sv =====
// Top level of the kd-tree volume ray traversal block.
// Node write, origin and unused commands are taken back to back while idle.
// Trace: accept, per axis a reciprocal (setup, 33 restoring steps, store; just setup and
// store for a zero direction), six clip multiplies (load, product, shift, clip), a clamp,
// then node fetch and check, split multiply and decide, stack pop; done loads the result.
// Reset clears config, origin and control; node table and stack are not cleared.
`timescale 1ns / 1ps
module kd_tree_volume_ray_traversal (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  kdt_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output kdt_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    kdt_pkg::dp_cmd_t    cmd;
    kdt_pkg::dp_status_t status;

    kdt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_cmd   (in_data.cmd),
        .in_stall (in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .cmd      (cmd),
        .status   (status)
    );

    kdt_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule

// ===== dv/tb_kd_tree_volume_ray_traversal.sv =====
// Self-checking testbench for the kd-tree volume ray traversal block.
`timescale 1ns / 1ps
module tb_kd_tree_volume_ray_traversal;

    localparam int CYCLE_LIMIT  = 250_000_000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int DRAIN_CYCLES = 64;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Scoreboard: mirrors the node table, origin and registers, and predicts each trace.
    class trace_scoreboard;
        logic [15:0] threshold;
        logic [11:0] root_node;
        longint      box_lo[3];
        longint      box_hi[3];
        longint      origin[3];
        logic [11:0] left_of[kdt_pkg::NODE_COUNT];
        logic [11:0] right_of[kdt_pkg::NODE_COUNT];
        logic [1:0]  axis_of[kdt_pkg::NODE_COUNT];
        longint      split_of[kdt_pkg::NODE_COUNT];
        logic [15:0] vmin_of[kdt_pkg::NODE_COUNT];
        logic [15:0] vmax_of[kdt_pkg::NODE_COUNT];
        kdt_pkg::out_item_t hits_due[$];
        int          errors;

        function new();
            threshold = '0;
            root_node = '0;
            errors    = 0;
            for (int a = 0; a < 3; a++)
            begin
                box_lo[a] = 0;
                box_hi[a] = 0;
                origin[a] = 0;
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        function longint sat32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function longint qmul(longint a, longint b);
            longint p;
            p = a * b;
            return sat32(p >>> kdt_pkg::FRAC_BITS);
        endfunction

        function longint qrecip(longint d);
            longint mag;
            longint q;
            if (d == 0)
                return 64'sd2147483647;
            mag = (d < 0) ? -d : d;
            q = (64'sd1 <<< (2 * kdt_pkg::FRAC_BITS)) / mag;
            if (q > 64'sd2147483647)
                q = 64'sd2147483647;
            return (d < 0) ? -q : q;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                kdt_pkg::REG_THRESHOLD: threshold = v[15:0];
                kdt_pkg::REG_ROOT_NODE: root_node = v[11:0];
                kdt_pkg::REG_BOX_MIN_X: box_lo[0] = longint'($signed(v));
                kdt_pkg::REG_BOX_MIN_Y: box_lo[1] = longint'($signed(v));
                kdt_pkg::REG_BOX_MIN_Z: box_lo[2] = longint'($signed(v));
                kdt_pkg::REG_BOX_MAX_X: box_hi[0] = longint'($signed(v));
                kdt_pkg::REG_BOX_MAX_Y: box_hi[1] = longint'($signed(v));
                kdt_pkg::REG_BOX_MAX_Z: box_hi[2] = longint'($signed(v));
                default: ;
            endcase
        endfunction

        function kdt_pkg::out_item_t trace_ray(longint dir[3]);
            longint      inv[3];
            longint      lo[3];
            longint      hi[3];
            longint      rmin;
            longint      rmax;
            longint      t;
            longint      st_lo[kdt_pkg::STACK_DEPTH];
            longint      st_hi[kdt_pkg::STACK_DEPTH];
            logic [11:0] st_node[kdt_pkg::STACK_DEPTH];
            logic [11:0] node;
            logic [11:0] near_c;
            logic [11:0] far_c;
            int          steps;
            int          depth;
            int          ax;
            kdt_pkg::out_item_t r;
            r = '0;
            node = root_node;
            steps = 0;
            depth = 0;
            for (int a = 0; a < 3; a++)
            begin
                inv[a] = qrecip(dir[a]);
                lo[a] = (dir[a] < 0) ? box_hi[a] : box_lo[a];
                hi[a] = (dir[a] < 0) ? box_lo[a] : box_hi[a];
                lo[a] = qmul(sat32(lo[a] - origin[a]), inv[a]);
                hi[a] = qmul(sat32(hi[a] - origin[a]), inv[a]);
            end
            rmin = lo[0];
            rmax = hi[0];
            for (int a = 1; a < 3; a++)
            begin
                if (lo[a] > rmin) rmin = lo[a];
                if (hi[a] < rmax) rmax = hi[a];
            end
            if (rmin < 0) rmin = 0;
            if (rmax < 0) rmax = 0;
            forever
            begin
                steps++;
                if (steps > kdt_pkg::VISIT_LIMIT)
                    return r;
                if (vmax_of[node] < threshold || rmin >= rmax)
                begin
                    if (depth == 0)
                        return r;
                    depth--;
                    rmin = st_lo[depth];
                    rmax = st_hi[depth];
                    node = st_node[depth];
                    continue;
                end
                if (axis_of[node] == kdt_pkg::AXIS_LEAF || vmin_of[node] == vmax_of[node])
                begin
                    r.hit_value = vmax_of[node];
                    return r;
                end
                ax = int'(axis_of[node]);
                near_c = (dir[ax] < 0) ? right_of[node] : left_of[node];
                far_c  = (dir[ax] < 0) ? left_of[node] : right_of[node];
                t = qmul(sat32(split_of[node] - origin[ax]), inv[ax]);
                if (rmax <= t)
                    node = near_c;
                else if (rmin >= t)
                    node = far_c;
                else
                begin
                    if (depth < kdt_pkg::STACK_DEPTH)
                    begin
                        st_lo[depth] = t;
                        st_hi[depth] = rmax;
                        st_node[depth] = far_c;
                        depth++;
                    end
                    else
                        r.stack_overflow = 1'b1;
                    rmax = t;
                    node = near_c;
                end
            end
        endfunction

        function void note_input(kdt_pkg::in_item_t it);
            longint dir[3];
            case (it.cmd)
                kdt_pkg::CMD_NODE:
                begin
                    left_of[it.node_index]  = it.left_child;
                    right_of[it.node_index] = it.right_child;
                    axis_of[it.node_index]  = it.split_axis;
                    split_of[it.node_index] = longint'(it.split_pos);
                    vmin_of[it.node_index]  = it.value_min;
                    vmax_of[it.node_index]  = it.value_max;
                end
                kdt_pkg::CMD_ORIGIN:
                begin
                    origin[0] = longint'(it.vec_x);
                    origin[1] = longint'(it.vec_y);
                    origin[2] = longint'(it.vec_z);
                end
                kdt_pkg::CMD_TRACE:
                begin
                    dir[0] = longint'(it.vec_x);
                    dir[1] = longint'(it.vec_y);
                    dir[2] = longint'(it.vec_z);
                    hits_due.insert(hits_due.size(), trace_ray(dir));
                end
                default: ;
            endcase
        endfunction

        task check_result(kdt_pkg::out_item_t got);
            kdt_pkg::out_item_t want;
            if (hits_due.size() == 0)
            begin
                report($sformatf("result with nothing pending: hit %0d ovf %0d",
                                 got.hit_value, got.stack_overflow));
                return;
            end
            want = hits_due.pop_front();
            if (got.hit_value !== want.hit_value)
                report($sformatf("hit_value got %0d want %0d", got.hit_value, want.hit_value));
            if (got.stack_overflow !== want.stack_overflow)
                report($sformatf("stack_overflow got %0d want %0d",
                                 got.stack_overflow, want.stack_overflow));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    kdt_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_stall;
    kdt_pkg::out_item_t out_data;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    trace_scoreboard sb;
    bit          calm;
    int          cycle_count;
    int          rand_count;
    int          bx_lo[3];
    int          bx_hi[3];

    kd_tree_volume_ray_traversal u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("kd_tree_volume_ray_traversal verification failed");
                $finish;
            end
        end
    end

    // Result side: check at each transfer, then pick the stall for the next cycle.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result(out_data);
            out_stall <= !calm && ($urandom_range(0, 99) < 24);
        end
    end

    function automatic kdt_pkg::in_item_t rand_item();
        kdt_pkg::in_item_t it;
        it.cmd         = 2'($urandom_range(0, 3));
        it.node_index  = 12'($urandom);
        it.left_child  = 12'($urandom);
        it.right_child = 12'($urandom);
        it.split_axis  = 2'($urandom);
        it.split_pos   = $urandom;
        it.value_min   = 16'($urandom);
        it.value_max   = 16'($urandom);
        it.vec_x       = $urandom;
        it.vec_y       = $urandom;
        it.vec_z       = $urandom;
        return it;
    endfunction

    function automatic kdt_pkg::in_item_t node_item(logic [11:0] idx, logic [11:0] l,
                                                    logic [11:0] r, logic [1:0] ax,
                                                    logic [31:0] split,
                                                    logic [15:0] vmin, logic [15:0] vmax);
        kdt_pkg::in_item_t it;
        it = rand_item();
        it.cmd         = kdt_pkg::CMD_NODE;
        it.node_index  = idx;
        it.left_child  = l;
        it.right_child = r;
        it.split_axis  = ax;
        it.split_pos   = split;
        it.value_min   = vmin;
        it.value_max   = vmax;
        return it;
    endfunction

    function automatic kdt_pkg::in_item_t vec_item(logic [1:0] cmd, logic [31:0] x,
                                                   logic [31:0] y, logic [31:0] z);
        kdt_pkg::in_item_t it;
        it = rand_item();
        it.cmd   = cmd;
        it.vec_x = x;
        it.vec_y = y;
        it.vec_z = z;
        return it;
    endfunction

    // Mostly inside the current box, now and then anywhere in the Q16.16 range.
    function automatic logic [31:0] rand_coord(int a);
        longint w;
        w = longint'(bx_hi[a]) - longint'(bx_lo[a]);
        if ($urandom_range(0, 7) == 0 || w <= 0 || w > 64'h3FFF_FFFF)
            return $urandom;
        return bx_lo[a] + int'($urandom_range(0, int'(w)));
    endfunction

    function automatic logic [31:0] rand_dir();
        int sel;
        int mag;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 32'd0;
        if (sel == 1)
            return $urandom;
        mag = $urandom_range(1, 32'h30000);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    task send(kdt_pkg::in_item_t it);
        while (!calm && $urandom_range(0, 99) < 24)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(it);
    endtask

    task write_reg(logic [2:0] idx, logic [31:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        sb.set_reg(idx, v);
    endtask

    task end_regs();
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Wait for every trace to answer, plus slack for trailing node writes.
    task settle();
        in_valid <= 1'b0;
        while (sb.hits_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task write_box();
        write_reg(kdt_pkg::REG_BOX_MIN_X, bx_lo[0]);
        write_reg(kdt_pkg::REG_BOX_MIN_Y, bx_lo[1]);
        write_reg(kdt_pkg::REG_BOX_MIN_Z, bx_lo[2]);
        write_reg(kdt_pkg::REG_BOX_MAX_X, bx_hi[0]);
        write_reg(kdt_pkg::REG_BOX_MAX_Y, bx_hi[1]);
        write_reg(kdt_pkg::REG_BOX_MAX_Z, bx_hi[2]);
    endtask

    // Random acyclic tree: each child points at a node written earlier; the first, a leaf, at itself.
    task tree_phase();
        logic [11:0] ids[24];
        int          n;
        int          base;
        int          stride;
        int          span;
        int          ops;
        int          sel;
        int          ax;
        logic [15:0] thr;
        logic [15:0] vmax;
        logic [15:0] vmin;
        kdt_pkg::in_item_t it;
        n = $urandom_range(1, 24);
        base = $urandom_range(0, 4095);
        stride = $urandom_range(0, 2047) * 2 + 1;
        for (int j = 0; j < n; j++)
            ids[j] = 12'(base + j * stride);
        sel = $urandom_range(0, 9);
        thr = 16'((sel < 6) ? $urandom_range(0, 300) : (sel < 8) ? 32'd0 :
                  (sel < 9) ? 32'hFFFF : $urandom);
        span = 1 << $urandom_range(16, 22);
        for (int a = 0; a < 3; a++)
        begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
            begin
                bx_lo[a] = $urandom;
                bx_hi[a] = $urandom;
            end
            else
            begin
                bx_lo[a] = $urandom_range(0, 2 * span) - span;
                bx_hi[a] = bx_lo[a] + $urandom_range(1, 2 * span);
                if (sel == 1)
                    bx_hi[a] = bx_lo[a] - $urandom_range(0, span);
            end
        end
        write_reg(kdt_pkg::REG_THRESHOLD, {16'd0, thr});
        write_reg(kdt_pkg::REG_ROOT_NODE, {20'd0, ids[n - 1]});
        write_box();
        end_regs();
        for (int j = 0; j < n; j++)
        begin
            ax = (j == 0) ? int'(kdt_pkg::AXIS_LEAF) : int'($urandom_range(0, 3));
            vmax = 16'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 400) : $urandom);
            sel = $urandom_range(0, 19);
            vmin = 16'((sel < 5) ? 32'(vmax) : (sel == 5) ? $urandom
                                              : $urandom_range(0, vmax));
            it = node_item(ids[j], ids[(j == 0) ? 0 : $urandom_range(0, j - 1)],
                           ids[(j == 0) ? 0 : $urandom_range(0, j - 1)], 2'(ax),
                           rand_coord((ax == int'(kdt_pkg::AXIS_LEAF)) ? 0 : ax),
                           vmin, vmax);
            send(it);
            rand_count++;
        end
        ops = $urandom_range(8, 30);
        for (int k = 0; k < ops; k++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 20)
                it = vec_item(kdt_pkg::CMD_ORIGIN, rand_coord(0), rand_coord(1),
                              rand_coord(2));
            else if (sel < 25)
            begin
                it = rand_item();
                it.cmd = CMD_UNUSED;
            end
            else
                it = vec_item(kdt_pkg::CMD_TRACE, rand_dir(), rand_dir(), rand_dir());
            send(it);
            if (sel >= 25 || sel < 20)
                rand_count++;
        end
        settle();
    endtask

    // Deep chain of ever closer splits along x: drives the walk past the stack depth.
    task chain_phase();
        logic [11:0] ids[72];
        int          n;
        int          base;
        int          stride;
        int          ops;
        int          sy;
        int          sz;
        n = $urandom_range(kdt_pkg::STACK_DEPTH + 2, 72);
        base = $urandom_range(0, 4095);
        stride = $urandom_range(0, 2047) * 2 + 1;
        for (int j = 0; j < n; j++)
            ids[j] = 12'(base + j * stride);
        bx_lo[0] = 0;
        bx_hi[0] = (n + 1) << 14;
        for (int a = 1; a < 3; a++)
        begin
            bx_lo[a] = -(1 << 24);
            bx_hi[a] = 1 << 24;
        end
        write_reg(kdt_pkg::REG_THRESHOLD, 32'd0);
        write_reg(kdt_pkg::REG_ROOT_NODE, {20'd0, ids[n - 1]});
        write_box();
        end_regs();
        send(node_item(ids[0], ids[0], ids[0], kdt_pkg::AXIS_LEAF, 32'd0, 16'd7,
                       16'($urandom)));
        for (int j = 1; j < n; j++)
            send(node_item(ids[j], ids[j - 1], ids[0], 2'd0, j << 14, 16'd0, 16'(j + 1)));
        send(vec_item(kdt_pkg::CMD_ORIGIN, 32'd0, $urandom_range(0, 32'h3FFFF),
                      $urandom_range(0, 32'h3FFFF)));
        rand_count += n + 1;
        ops = $urandom_range(4, 10);
        for (int k = 0; k < ops; k++)
        begin
            sy = $urandom_range(0, 32'h800);
            sz = $urandom_range(0, 32'h800);
            send(vec_item(kdt_pkg::CMD_TRACE, $urandom_range(32'h8000, 32'h20000),
                          $urandom_range(0, 1) ? -sy : sy, $urandom_range(0, 1) ? -sz : sz));
            rand_count++;
        end
        settle();
    endtask

    initial
    begin
        kdt_pkg::in_item_t it;
        sb = new();
        calm = 1'b0;
        rand_count = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extreme box and registers, zero and full-scale directions, unused command.
        write_reg(kdt_pkg::REG_THRESHOLD, 32'd0);
        write_reg(kdt_pkg::REG_ROOT_NODE, 32'd4095);
        for (int a = 0; a < 3; a++)
        begin
            bx_lo[a] = 32'h8000_0000;
            bx_hi[a] = 32'h7FFF_FFFF;
        end
        write_box();
        end_regs();
        send(node_item(12'd4095, 12'd4095, 12'd0, kdt_pkg::AXIS_LEAF, 32'h7FFF_FFFF,
                       16'd0, 16'hFFFF));
        send(node_item(12'd0, 12'd0, 12'd4095, kdt_pkg::AXIS_LEAF, 32'h8000_0000,
                       16'hFFFF, 16'hFFFF));
        send(vec_item(kdt_pkg::CMD_ORIGIN, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0));
        send(vec_item(kdt_pkg::CMD_TRACE, 32'd0, 32'd0, 32'd0));
        send(vec_item(kdt_pkg::CMD_TRACE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
        it = rand_item();
        it.cmd = CMD_UNUSED;
        send(it);
        send(vec_item(kdt_pkg::CMD_TRACE, 32'h0001_0000, 32'd0, 32'd0));
        settle();

        // Top threshold: hit at root, empty interval, then self loop, split and skip.
        write_reg(kdt_pkg::REG_THRESHOLD, 32'h0000_FFFF);
        write_reg(kdt_pkg::REG_ROOT_NODE, 32'd0);
        for (int a = 0; a < 3; a++)
        begin
            bx_lo[a] = 0;
            bx_hi[a] = 10 << 16;
        end
        write_box();
        end_regs();
        send(node_item(12'd5, 12'd5, 12'd5, 2'd0, 100 << 16, 16'd1, 16'hFFFF));
        send(node_item(12'd6, 12'd0, 12'd4095, 2'd1, 5 << 16, 16'd0, 16'hFFFF));
        send(node_item(12'd7, 12'd0, 12'd0, 2'd2, 32'd0, 16'd0, 16'd100));
        send(vec_item(kdt_pkg::CMD_ORIGIN, 32'd0, 32'd0, 32'd0));
        send(vec_item(kdt_pkg::CMD_TRACE, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        send(vec_item(kdt_pkg::CMD_ORIGIN, 20 << 16, 32'd0, 32'd0));
        send(vec_item(kdt_pkg::CMD_TRACE, 32'h0001_0000, 32'h0001_0000, 32'h0000_8000));
        send(vec_item(kdt_pkg::CMD_ORIGIN, 32'd0, 32'd0, 32'd0));
        settle();
        write_reg(kdt_pkg::REG_ROOT_NODE, 32'd5);
        end_regs();
        send(vec_item(kdt_pkg::CMD_TRACE, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        settle();
        write_reg(kdt_pkg::REG_ROOT_NODE, 32'd6);
        end_regs();
        send(vec_item(kdt_pkg::CMD_TRACE, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        send(vec_item(kdt_pkg::CMD_TRACE, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000));
        settle();
        write_reg(kdt_pkg::REG_ROOT_NODE, 32'd7);
        end_regs();
        send(vec_item(kdt_pkg::CMD_TRACE, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        settle();

        while (rand_count < RANDOM_ITEMS)
        begin
            calm = (rand_count >= 400 && rand_count < 650);
            if ($urandom_range(0, 7) == 0)
                chain_phase();
            else
                tree_phase();
        end
        calm = 1'b0;
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("kd_tree_volume_ray_traversal verification clean");
        else
            $display("kd_tree_volume_ray_traversal verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/kdt_pkg.sv
src/kdt_ram.sv
src/kdt_datapath.sv
src/kdt_ctrl.sv
src/kd_tree_volume_ray_traversal.sv
dv/tb_kd_tree_volume_ray_traversal.sv
